FILE: rtl/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the first-fit region allocator: field widths,
// status codes, register indexes, controller states and the command and
// status bundles that join controller and datapath.
// ----------------------------------------------------------------------------
package ffra_pkg;

    // Field widths of the stream beats and of the configuration port.
    localparam int PAGE_W    = 20;
    localparam int SIZE_W    = 11;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 20;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 40;

    // Default sizing of the region table and the window.
    localparam int DEF_MAX_REGIONS      = 16;
    localparam int DEF_MAX_WINDOW_PAGES = 1024;

    // Reset values of the configuration registers.
    localparam logic [PAGE_W-1:0] RST_WINDOW_BASE  = 20'd1047552;
    localparam logic [SIZE_W-1:0] RST_WINDOW_PAGES = 11'd512;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_PAGES = 1'b1;

    // Request opcodes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_BADSIZE  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_MISMATCH = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_EV,
        S_INS_RD,
        S_INS_MV,
        S_INS_NEW,
        S_FIND_RD,
        S_FIND_EV,
        S_DEL_RD,
        S_DEL_MV,
        S_DONE
    } t_state;

    // Table read address relative to the walk index.
    typedef enum logic [1:0] {
        RD_IDX,
        RD_PREV,
        RD_NEXT
    } t_rd_sel;

    // Source of the result fields.
    typedef enum logic [1:0] {
        RES_FAIL,
        RES_ALLOC,
        RES_FREE
    } t_res_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     init_alloc;
        logic     init_free;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        logic     wr_new;
        logic     idx_inc;
        logic     idx_dec;
        logic     addr_ld;
        logic     set_pos;
        logic     take_actual;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     res_ld;
        t_res_sel res_sel;
        t_status  res_status;
        logic     out_ld;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic bad_size;
        logic full;
        logic at_count;
        logic idx_is_pos;
        logic fits_here;
        logic past_limit;
        logic match;
        logic last_entry;
        logic out_room;
    } t_sts;

endpackage

FILE: rtl/ffra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer of the allocator: takes a request beat, walks the region table
// through the datapath, shifts entries to insert or remove one, and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module ffra_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ffra_pkg::t_sts i_sts,
    output ffra_pkg::t_cmd o_cmd
);
    import ffra_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.is_free) begin
                    o_cmd.init_free = 1'b1;
                    n_state         = S_FIND_RD;
                end else if (i_sts.bad_size) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_sel    = RES_FAIL;
                    o_cmd.res_status = ST_BADSIZE;
                    n_state          = S_DONE;
                end else if (i_sts.full) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_sel    = RES_FAIL;
                    o_cmd.res_status = ST_NOSPACE;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.init_alloc = 1'b1;
                    n_state          = S_SCAN_RD;
                end
            end
            // First-fit walk: fetch one entry, then test the gap ahead of it.
            S_SCAN_RD: begin
                if (i_sts.at_count) begin
                    o_cmd.set_pos = 1'b1;
                    n_state       = S_INS_RD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (i_sts.fits_here) begin
                    o_cmd.set_pos = 1'b1;
                    n_state       = S_INS_RD;
                end else if (i_sts.past_limit) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_sel    = RES_FAIL;
                    o_cmd.res_status = ST_NOSPACE;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.addr_ld = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            // Open a hole at the insert position, moving entries up by one.
            S_INS_RD: begin
                if (i_sts.idx_is_pos) begin
                    n_state = S_INS_NEW;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PREV;
                    n_state      = S_INS_MV;
                end
            end
            S_INS_MV: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.idx_dec = 1'b1;
                n_state       = S_INS_RD;
            end
            S_INS_NEW: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_new     = 1'b1;
                o_cmd.cnt_inc    = 1'b1;
                o_cmd.res_ld     = 1'b1;
                o_cmd.res_sel    = RES_ALLOC;
                o_cmd.res_status = ST_OK;
                n_state          = S_DONE;
            end
            // Lookup of the region to free.
            S_FIND_RD: begin
                if (i_sts.at_count) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_sel    = RES_FAIL;
                    o_cmd.res_status = ST_NOTFOUND;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = S_FIND_EV;
                end
            end
            S_FIND_EV: begin
                if (i_sts.match) begin
                    o_cmd.take_actual = 1'b1;
                    n_state           = S_DEL_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_FIND_RD;
                end
            end
            // Close the gap, moving later entries down by one.
            S_DEL_RD: begin
                if (i_sts.last_entry) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = RES_FREE;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_DEL_MV;
                end
            end
            S_DEL_MV: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_DEL_RD;
            end
            S_DONE: begin
                if (i_sts.out_room) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/ffra_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_datapath
// Region table memory, walk registers, window configuration, comparators
// and the result and output registers of the allocator.
// ----------------------------------------------------------------------------
module ffra_datapath #(
    parameter int MAX_REGIONS      = ffra_pkg::DEF_MAX_REGIONS,
    parameter int MAX_WINDOW_PAGES = ffra_pkg::DEF_MAX_WINDOW_PAGES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ffra_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic [ffra_pkg::IN_USER_W-1:0]  i_in_user,
    input  logic                            i_cfg_we,
    input  logic [ffra_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ffra_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [ffra_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  ffra_pkg::t_cmd                  i_cmd,
    output ffra_pkg::t_sts                  o_sts
);
    import ffra_pkg::*;

    // The window register is 11 bits wide, so offsets never exceed 2047.
    localparam int WIN_LIM = (MAX_WINDOW_PAGES > 2047) ? 2047 : MAX_WINDOW_PAGES;
    localparam int OFS_W   = $clog2(WIN_LIM + 1);
    localparam int IDX_W   = $clog2(MAX_REGIONS + 1);
    localparam int AW      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int ENT_W   = 2 * OFS_W;

    // Configuration registers.
    logic [PAGE_W-1:0] r_base;
    logic [SIZE_W-1:0] r_win_pages;

    // Request and walk registers.
    logic              r_op;
    logic [SIZE_W-1:0] r_size;
    logic [PAGE_W-1:0] r_start;
    logic [PAGE_W-1:0] r_off;
    logic [OFS_W-1:0]  r_addr;
    logic [OFS_W-1:0]  r_limit;
    logic [OFS_W-1:0]  r_actual;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_count;

    // Table memory and its registered read data.
    logic [ENT_W-1:0]  r_mem [MAX_REGIONS];
    logic [ENT_W-1:0]  r_rd_data;

    // Result and output registers.
    t_status           r_res_status;
    logic [PAGE_W-1:0] r_res_start;
    logic [SIZE_W-1:0] r_res_size;
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [SIZE_W-1:0] win;
    logic [OFS_W-1:0]  size_o;
    logic [OFS_W-1:0]  rd_begin;
    logic [OFS_W-1:0]  rd_finish;
    logic [IDX_W-1:0]  rd_ptr;
    logic [IDX_W-1:0]  wr_ptr;
    logic [ENT_W-1:0]  wr_data;
    logic              mismatch;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= RST_WINDOW_BASE;
            r_win_pages <= RST_WINDOW_PAGES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_BASE:  r_base      <= i_cfg_data;
                CFG_WINDOW_PAGES: r_win_pages <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective window and derived values.
    assign win       = (r_win_pages > SIZE_W'(WIN_LIM)) ? SIZE_W'(WIN_LIM) : r_win_pages;
    assign size_o    = r_size[OFS_W-1:0];
    assign rd_begin  = r_rd_data[OFS_W-1:0];
    assign rd_finish = r_rd_data[ENT_W-1:OFS_W];
    assign mismatch  = (SIZE_W'(r_actual) != r_size);

    // Request capture and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_in_user[0];
            r_size  <= i_in_data[SIZE_W-1:0];
            r_start <= i_in_data[SIZE_W+PAGE_W-1:SIZE_W];
        end
        if (i_cmd.init_alloc) begin
            r_addr  <= '0;
            r_limit <= OFS_W'(win - r_size);
        end else if (i_cmd.addr_ld) begin
            r_addr  <= rd_finish;
        end
        if (i_cmd.init_free) begin
            r_off <= r_start - r_base;
        end
        if (i_cmd.take_actual) begin
            r_actual <= rd_finish - rd_begin;
        end
        if (i_cmd.init_alloc || i_cmd.init_free) begin
            r_idx <= '0;
        end else if (i_cmd.set_pos) begin
            r_pos <= r_idx;
            r_idx <= r_count;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    // Region count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Table addressing.
    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV: rd_ptr = r_idx - 1'b1;
            RD_NEXT: rd_ptr = r_idx + 1'b1;
            default: rd_ptr = r_idx;
        endcase
    end
    assign wr_ptr  = i_cmd.wr_new ? r_pos : r_idx;
    assign wr_data = i_cmd.wr_new ? {r_addr + size_o, r_addr} : r_rd_data;

    // Table memory: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_ptr[AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_ptr[AW-1:0]];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            case (i_cmd.res_sel)
                RES_ALLOC: begin
                    r_res_status <= ST_OK;
                    r_res_start  <= r_base + PAGE_W'(r_addr);
                    r_res_size   <= r_size;
                end
                RES_FREE: begin
                    r_res_status <= mismatch ? ST_MISMATCH : ST_OK;
                    r_res_start  <= r_start;
                    r_res_size   <= SIZE_W'(r_actual);
                end
                default: begin
                    r_res_status <= i_cmd.res_status;
                    r_res_start  <= '0;
                    r_res_size   <= '0;
                end
            endcase
        end
    end

    // Output register: holds a beat until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_data <= {(OUT_DATA_W - STATUS_W - PAGE_W - SIZE_W)'(0),
                           r_res_size, r_res_start, r_res_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Status to the controller.
    assign o_sts.is_free    = (r_op == OP_FREE);
    assign o_sts.bad_size   = (r_size == '0) || (r_size >= win);
    assign o_sts.full       = (r_count == IDX_W'(MAX_REGIONS));
    assign o_sts.at_count   = (r_idx == r_count);
    assign o_sts.idx_is_pos = (r_idx == r_pos);
    assign o_sts.fits_here  = ({1'b0, r_addr} + {1'b0, size_o}) <= {1'b0, rd_begin};
    assign o_sts.past_limit = (rd_finish > r_limit);
    assign o_sts.match      = (PAGE_W'(rd_begin) == r_off);
    assign o_sts.last_entry = ({1'b0, r_idx} + 1'b1) >= {1'b0, r_count};
    assign o_sts.out_room   = !r_out_valid || i_m_tready;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IDX_W'(MAX_REGIONS))
        else $error("region count above table depth");

    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> (r_count < IDX_W'(MAX_REGIONS)))
        else $error("insert into a full table");

    a_remove_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> (r_count != '0))
        else $error("remove from an empty table");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> (!r_out_valid || i_m_tready))
        else $error("result beat overwritten before it was taken");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_ld && (r_res_status == ST_NOSPACE || r_res_status == ST_BADSIZE ||
                          r_res_status == ST_NOTFOUND))
        |=> (o_m_tdata[OUT_DATA_W-1:STATUS_W] == '0))
        else $error("failed request reports a nonzero region");
`endif

endmodule

FILE: rtl/first_fit_region_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// First-fit page-range allocator over a configurable address window.
// ----------------------------------------------------------------------------
// Usage:
// Request beats enter on the slave stream: tuser[0] is the opcode
// (allocate or free), tdata carries the size and the start page. Each
// request gives exactly one result beat on the master stream with status,
// region start and region size. The user sets window base and size through
// the write port only while the block is idle; the block does not enforce it.
// One request is worked on at a time. The region table sits in a memory
// with one write and one read port, and each visited entry takes a read
// state, then a test or move state. Walk and shift together touch at most
// count + 1 entries, where count is the number of regions held. Requests
// that fail the size check go straight to the result without a table walk.
// The result sits in an output register, so a stalled receiver holds only
// that beat; the block keeps accepting one more request and parks its
// result until the output register frees up.
// Reset clears the region count, the output valid and sets the window
// registers to their defaults; the table needs no clearing.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_core #(
    parameter int MAX_REGIONS      = ffra_pkg::DEF_MAX_REGIONS,
    parameter int MAX_WINDOW_PAGES = ffra_pkg::DEF_MAX_WINDOW_PAGES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request beat.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: size_pages[10:0], start_page[30:11], zero[31].
    input  logic [ffra_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: opcode[0].
    input  logic [ffra_pkg::IN_USER_W-1:0]  i_s_tuser,
    // Result beat.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: status[2:0], region_start[22:3], region_size[33:23], zero[39:34].
    output logic [ffra_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [ffra_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ffra_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import ffra_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    ffra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Table, arithmetic and output register.
    ffra_datapath #(
        .MAX_REGIONS      (MAX_REGIONS),
        .MAX_WINDOW_PAGES (MAX_WINDOW_PAGES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_s_tdata),
        .i_in_user  (i_s_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

FILE: test/ffra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_checker
// Watches the request, result and configuration ports of the first-fit region
// allocator. Every accepted request is run through a local first-fit table
// model. The outcome is queued and compared with the next result beat.
// ----------------------------------------------------------------------------
module ffra_checker #(
    parameter int MAX_REGIONS      = ffra_pkg::DEF_MAX_REGIONS,
    parameter int MAX_WINDOW_PAGES = ffra_pkg::DEF_MAX_WINDOW_PAGES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // tdata: size_pages[10:0], start_page[30:11], zero[31].
    input  logic [ffra_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: opcode[0].
    input  logic [ffra_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: status[2:0], region_start[22:3], region_size[33:23], zero[39:34].
    input  logic [ffra_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [ffra_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ffra_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import ffra_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [PAGE_W-1:0] start;
        logic [SIZE_W-1:0] pages;
    } t_outcome;

    // Window registers and the sorted table of held ranges, as offsets.
    logic [PAGE_W-1:0] win_base;
    logic [SIZE_W-1:0] win_pages;
    int unsigned       seg_lo [MAX_REGIONS];
    int unsigned       seg_hi [MAX_REGIONS];
    int unsigned       seg_count;
    t_outcome          outcome_q [$];
    int                fail_total = 0;

    // First-fit placement of a new range; inserts it into the table on success.
    function automatic t_outcome place_region(int unsigned req);
        t_outcome    r;
        int unsigned win, lim, addr, pos, i;
        bit          fits;
        r = '{ST_BADSIZE, '0, '0};
        win = (win_pages > MAX_WINDOW_PAGES) ? MAX_WINDOW_PAGES : win_pages;
        if (req == 0 || req >= win) return r;
        r.status = ST_NOSPACE;
        if (seg_count >= MAX_REGIONS) return r;
        lim  = win - req;
        addr = 0;
        pos  = seg_count;
        fits = 1'b1;
        for (i = 0; i < seg_count; i++) begin
            if (addr + req <= seg_lo[i]) begin
                pos = i;
                break;
            end
            addr = seg_hi[i];
            if (addr > lim) begin
                fits = 1'b0;
                break;
            end
        end
        if (!fits) return r;
        for (i = seg_count; i > pos; i--) begin
            seg_lo[i] = seg_lo[i-1];
            seg_hi[i] = seg_hi[i-1];
        end
        seg_lo[pos] = addr;
        seg_hi[pos] = addr + req;
        seg_count++;
        r.status = ST_OK;
        r.start  = win_base + PAGE_W'(addr);
        r.pages  = SIZE_W'(req);
        return r;
    endfunction

    // Removes the range whose offset matches the given absolute start page.
    function automatic t_outcome release_region(logic [SIZE_W-1:0] stated,
                                                logic [PAGE_W-1:0] start);
        t_outcome          r;
        logic [PAGE_W-1:0] off;
        int unsigned       i, k, actual;
        r   = '{ST_NOTFOUND, '0, '0};
        off = start - win_base;
        k   = seg_count;
        for (i = 0; i < seg_count; i++) begin
            if (seg_lo[i] == off) begin
                k = i;
                break;
            end
        end
        if (k == seg_count) return r;
        actual   = seg_hi[k] - seg_lo[k];
        r.status = (actual != stated) ? ST_MISMATCH : ST_OK;
        r.start  = start;
        r.pages  = SIZE_W'(actual);
        for (i = k; i + 1 < seg_count; i++) begin
            seg_lo[i] = seg_lo[i+1];
            seg_hi[i] = seg_hi[i+1];
        end
        seg_count--;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_outcome want,
                                   input t_outcome seen);
        fail_total++;
        if (fail_total <= 10) begin
            $display("[%0t] %s: expected status %0d start 0x%05h pages %0d,",
                     $time, what, want.status, want.start, want.pages);
            $display("    got status %0d start 0x%05h pages %0d",
                     seen.status, seen.start, seen.pages);
        end
    endtask

    // Register writes, request beats and result beats, all taken at the clock edge.
    always @(posedge i_clk) begin : monitor
        t_outcome seen;
        t_outcome want;
        if (!i_rst_n) begin
            win_base  = RST_WINDOW_BASE;
            win_pages = RST_WINDOW_PAGES;
            seg_count = 0;
            outcome_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WINDOW_BASE) begin
                    win_base = i_cfg_data[PAGE_W-1:0];
                end else if (i_cfg_idx == CFG_WINDOW_PAGES) begin
                    win_pages = i_cfg_data[SIZE_W-1:0];
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == OP_ALLOC) begin
                    outcome_q.push_back(place_region(i_s_tdata[SIZE_W-1:0]));
                end else begin
                    outcome_q.push_back(release_region(i_s_tdata[SIZE_W-1:0],
                                                       i_s_tdata[SIZE_W +: PAGE_W]));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.status = t_status'(i_m_tdata[STATUS_W-1:0]);
                seen.start  = i_m_tdata[STATUS_W +: PAGE_W];
                seen.pages  = i_m_tdata[STATUS_W+PAGE_W +: SIZE_W];
                if (outcome_q.size() == 0) begin
                    report_mismatch("result beat with no request outstanding", '0, seen);
                end else begin
                    want = outcome_q.pop_front();
                    if (seen.status != want.status || seen.start != want.start ||
                        seen.pages != want.pages) begin
                        report_mismatch("result mismatch", want, seen);
                    end
                end
            end
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: test/tb_first_fit_region_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_region_allocator_core
// Drives allocate and free requests through the region allocator under
// several window settings, with random gaps on both streams and long result
// stalls. A directed opening covers size limits, gaps, full table, unknown
// starts and size mismatches; in the random part most frees target ranges the
// block handed out. Checking is done by ffra_checker.
// ----------------------------------------------------------------------------
module tb_first_fit_region_allocator_core;
    import ffra_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE       = 60;

    // A range the block reported as allocated, kept as a window offset.
    typedef struct {
        logic [PAGE_W-1:0] offset;
        logic [SIZE_W-1:0] pages;
    } t_held;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;

    int                n_fail;
    int                n_pending;
    int                cycle_count = 0;
    int                tx_burst    = 0;
    logic [PAGE_W-1:0] cur_base    = RST_WINDOW_BASE;
    logic [SIZE_W-1:0] cur_pages   = RST_WINDOW_PAGES;
    t_held             held [$];
    logic              sent_ops [$];

    always #CLK_HALF i_clk = ~i_clk;

    first_fit_region_allocator_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ffra_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (n_fail),
        .o_pending    (n_pending)
    );

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sends one request beat after a random gap; returns at the falling edge
    // after acceptance with tvalid still high.
    task automatic send_request(input logic op, input logic [SIZE_W-1:0] pages,
                                input logic [PAGE_W-1:0] start);
        int gap;
        gap = (tx_burst > 0) ? 0 : $urandom_range(0, 8);
        if (tx_burst > 0) begin
            tx_burst--;
        end else if ($urandom_range(0, 40) == 0) begin
            tx_burst = $urandom_range(10, 30);
        end
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  = {1'b0, start, pages};
        s_tuser  = op;
        s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_ops.push_back(op);
        @(negedge i_clk);
    endtask

    // Mostly allocates of sizes scaled to the window and frees of held ranges.
    task automatic send_random();
        int unsigned       eff, cap, roll, pick;
        t_held             h;
        logic [SIZE_W-1:0] pages;
        eff  = (cur_pages > DEF_MAX_WINDOW_PAGES) ? DEF_MAX_WINDOW_PAGES : cur_pages;
        cap  = (eff > 24) ? eff / 12 : 1;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                pages = SIZE_W'($urandom_range(1, cap));
            end else if (pick < 19) begin
                pages = SIZE_W'($urandom_range(0, 1024));
            end else begin
                pages = SIZE_W'($urandom);
            end
            send_request(OP_ALLOC, pages, PAGE_W'($urandom));
        end else if (roll < 93 && held.size() > 0) begin
            pick = $urandom_range(0, held.size() - 1);
            h = held[pick];
            held.delete(pick);
            pages = ($urandom_range(0, 4) == 0) ? SIZE_W'($urandom) : h.pages;
            send_request(OP_FREE, pages, cur_base + h.offset);
        end else begin
            send_request(OP_FREE, SIZE_W'($urandom), PAGE_W'($urandom));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    // Stops sending and waits until every outstanding result has come back.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (n_pending != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [PAGE_W-1:0] base,
                             input logic [SIZE_W-1:0] pages, input int count);
        drain_results();
        write_reg(CFG_WINDOW_BASE, base);
        write_reg(CFG_WINDOW_PAGES, CFG_DAT_W'(pages));
        cur_base  = base;
        cur_pages = pages;
        repeat (count) send_random();
    endtask

    // Result sink: random stalls, occasional full-rate bursts and two long
    // holds that back the block up into its request port.
    initial begin : result_sink
        int    stall;
        int    beats;
        int    burst;
        logic  op;
        t_held h;
        beats = 0;
        burst = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (beats == 150 || beats == 420) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (burst > 0) begin
                burst--;
            end else begin
                stall = $urandom_range(0, 8);
                if (stall > 0) begin
                    m_tready = 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                if ($urandom_range(0, 40) == 0) burst = $urandom_range(10, 30);
            end
            m_tready = 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            // Remember each successful allocate so later frees can hit it.
            if (sent_ops.size() > 0) begin
                op = sent_ops.pop_front();
                if (op == OP_ALLOC && m_tdata[STATUS_W-1:0] == ST_OK) begin
                    h.offset = m_tdata[STATUS_W +: PAGE_W] - cur_base;
                    h.pages  = m_tdata[STATUS_W+PAGE_W +: SIZE_W];
                    held.push_back(h);
                end
            end
            beats++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Size limits at the reset window of 512 pages.
        send_request(OP_ALLOC, 11'd0, '0);
        send_request(OP_ALLOC, 11'd512, '1);
        send_request(OP_ALLOC, 11'd1024, '0);
        send_request(OP_ALLOC, 11'd2047, '0);
        // Fill the window exactly, then one more page finds no gap.
        send_request(OP_ALLOC, 11'd511, '0);
        send_request(OP_ALLOC, 11'd1, '0);
        send_request(OP_ALLOC, 11'd1, '0);
        // Exact free, repeated free, free with a wrong size, unknown start.
        send_request(OP_FREE, 11'd511, RST_WINDOW_BASE);
        send_request(OP_FREE, 11'd511, RST_WINDOW_BASE);
        send_request(OP_FREE, 11'd9, PAGE_W'(RST_WINDOW_BASE + 511));
        send_request(OP_FREE, 11'd0, '1);
        // Fill the table, then ask once more with it full.
        repeat (DEF_MAX_REGIONS) send_request(OP_ALLOC, 11'd30, '0);
        send_request(OP_ALLOC, 11'd1, '0);
        repeat (80) send_random();

        // Window settings, including wrap past the top page, a clamped size
        // register, tiny and empty windows, and shrinking over held ranges.
        run_phase(20'h00000, 11'd1024, 80);
        run_phase(20'hFFFFF, 11'd2047, 80);
        run_phase(20'hFFF00, 11'd1024, 80);
        run_phase(20'h5A5A5, 11'd2, 80);
        run_phase(20'h12345, 11'd1, 25);
        run_phase(20'h12345, 11'd0, 25);
        run_phase(20'hA5A5A, 11'd64, 80);
        run_phase(20'h00400, 11'd700, 80);

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (n_fail == 0 && n_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
